// File: design/stbs_pkg.sv
// Shared types and constants for the sorted-table binary search unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package stbs_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int VALUE_W  = 32;
  localparam int REQ_W    = 2;
  localparam int OUT_IDX_W = 10;
  localparam int OUT_CNT_W = 11;
  localparam int OUT_DATA_W = 24;

  // Request codes carried on the input tuser.
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_FINISH
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_req;
    logic issue_read;
    logic do_compare;
    logic publish;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic window_empty;
    logic key_hit;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/sorted_table_binary_search_unit.sv
// Sorted-table binary search unit. Each input transfer carries a request on
// in_tuser (clear, append, search) and a signed 32-bit operand on in_tdata; each
// request yields exactly one result transfer. Clear, append and the unused code go
// from acceptance straight to the finish state, which loads the result register. A
// search ends on a hit in the compare state, or on a miss in the probe state once
// the window is empty; one probe is a read of the table memory's single read port
// followed by a compare, and with n entries there are at most floor(log2(n)) + 1
// probes. The next request is taken in the cycle after the result register
// is loaded. One request is in work at a time; the next is accepted while the
// previous result still waits on the output, and a result that cannot be loaded
// because the previous one still waits holds the unit until that transfer
// completes. The table contents have no reset: only the count is cleared.
`default_nettype none

module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] operand_value
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [0] found, [10:1] match_index,
                                       // [11] table_full_error, [22:12] entry_count
);

  stbs_pkg::ctrl_cmd_t  cmd;
  stbs_pkg::dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_type   (in_tuser),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_type      (in_tuser),
    .operand_value (in_tdata),
    .cmd           (cmd),
    .status        (status),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata)
  );

endmodule

`default_nettype wire

// File: design/stbs_ctrl.sv
// Controller state machine of the sorted-table binary search unit.
// Sequences request intake, probe reads, compares and result hand-off; uses stbs_pkg.
`default_nettype none

module stbs_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [stbs_pkg::REQ_W-1:0]   req_type,
  input  wire logic                         out_tready,
  input  wire stbs_pkg::dp_status_t         status,
  output stbs_pkg::ctrl_cmd_t               cmd
);

  stbs_pkg::ctrl_state_t state_r;
  stbs_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      stbs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take_req = 1'b1;
          if (req_type == stbs_pkg::REQ_SEARCH) begin
            state_nxt = stbs_pkg::ST_PROBE;
          end else begin
            state_nxt = stbs_pkg::ST_FINISH;
          end
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (status.window_empty) begin
          state_nxt = stbs_pkg::ST_FINISH;
        end else begin
          cmd.issue_read = 1'b1;
          state_nxt      = stbs_pkg::ST_COMPARE;
        end
      end
      stbs_pkg::ST_COMPARE: begin
        cmd.do_compare = 1'b1;
        if (status.key_hit) begin
          state_nxt = stbs_pkg::ST_FINISH;
        end else begin
          state_nxt = stbs_pkg::ST_PROBE;
        end
      end
      stbs_pkg::ST_FINISH: begin
        // The result register is free, or its transfer completes this cycle.
        if (!status.out_busy || out_tready) begin
          cmd.publish = 1'b1;
          state_nxt   = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/stbs_dp.sv
// Datapath of the sorted-table binary search unit: table memory, fill count,
// search window, compare and the result register. Driven by stbs_ctrl; uses stbs_pkg.
`default_nettype none

module stbs_dp #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [stbs_pkg::REQ_W-1:0]          req_type,
  input  wire logic [stbs_pkg::VALUE_W-1:0]        operand_value,
  input  wire stbs_pkg::ctrl_cmd_t                 cmd,
  output stbs_pkg::dp_status_t                     status,
  input  wire logic                                out_tready,
  output logic                                     out_tvalid,
  output logic [stbs_pkg::OUT_DATA_W-1:0]          out_tdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  logic [stbs_pkg::VALUE_W-1:0] table_mem [TABLE_DEPTH];

  logic [CNT_W-1:0]                    fill_count_r;
  logic [CNT_W-1:0]                    lo_r;
  logic [CNT_W-1:0]                    hi_r;
  logic [CNT_W-1:0]                    mid_r;
  logic [CNT_W-1:0]                    mid;
  logic signed [stbs_pkg::VALUE_W-1:0] key_r;
  logic signed [stbs_pkg::VALUE_W-1:0] rdata_r;
  logic                                found_r;
  logic [CNT_W-1:0]                    index_r;
  logic                                full_err_r;
  logic                                out_valid_r;
  logic [stbs_pkg::OUT_DATA_W-1:0]     out_data_r;

  logic                                table_full;
  logic                                do_append;
  logic [CNT_W+stbs_pkg::OUT_CNT_W-1:0] count_ext;
  logic [CNT_W+stbs_pkg::OUT_IDX_W-1:0] index_ext;

  assign table_full = (fill_count_r == DEPTH_CNT);
  assign do_append  = cmd.take_req && (req_type == stbs_pkg::REQ_APPEND) && !table_full;
  assign mid        = lo_r + ((hi_r - lo_r) >> 1);

  assign status.window_empty = (hi_r <= lo_r);
  assign status.key_hit      = (rdata_r == key_r);
  assign status.out_busy     = out_valid_r;

  // Table memory: one write port for appends, one registered read port for probes.
  always_ff @(posedge clk) begin
    if (do_append) begin
      table_mem[fill_count_r[IDX_W-1:0]] <= operand_value;
    end
    if (cmd.issue_read) begin
      rdata_r <= table_mem[mid[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
    end else if (cmd.take_req) begin
      case (req_type)
        stbs_pkg::REQ_CLEAR:  fill_count_r <= '0;
        stbs_pkg::REQ_APPEND: begin
          if (!table_full) begin
            fill_count_r <= fill_count_r + CNT_W'(1);
          end
        end
        default: fill_count_r <= fill_count_r;
      endcase
    end
  end

  // Search window and per-request result fields.
  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      key_r      <= operand_value;
      lo_r       <= '0;
      hi_r       <= fill_count_r;
      found_r    <= 1'b0;
      index_r    <= '0;
      full_err_r <= (req_type == stbs_pkg::REQ_APPEND) && table_full;
    end
    if (cmd.issue_read) begin
      mid_r <= mid;
    end
    if (cmd.do_compare) begin
      if (rdata_r == key_r) begin
        found_r <= 1'b1;
        index_r <= mid_r;
      end else if (key_r < rdata_r) begin
        hi_r <= mid_r;
      end else begin
        lo_r <= mid_r + CNT_W'(1);
      end
    end
  end

  // Widen then cut, so the fixed output fields follow any table depth.
  assign count_ext = {{stbs_pkg::OUT_CNT_W{1'b0}}, fill_count_r};
  assign index_ext = {{stbs_pkg::OUT_IDX_W{1'b0}}, index_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r <= {1'b0,
                     count_ext[stbs_pkg::OUT_CNT_W-1:0],
                     full_err_r,
                     index_ext[stbs_pkg::OUT_IDX_W-1:0],
                     found_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted-table binary search unit: directed and random
// clear, append and search requests, checked against a behavioural copy of the table.
// Depends on stbs_pkg and sorted_table_binary_search_unit.

module testbench;
  import stbs_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int ITEM_TARGET = 1800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [31:0]      operand;
  } request_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_IDX_W-1:0] match_index;
    logic                 full_err;
    logic [OUT_CNT_W-1:0] entry_count;
  } search_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  sorted_table_binary_search_unit #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Behavioural copy of the table and the stimulus bookkeeping.
  logic signed [31:0] shadow_values [DEPTH];
  int unsigned        shadow_count = 0;
  search_result_t     expected_results [$];
  request_t           pending_requests [$];
  int                 loaded_keys [$];
  int                 stim_total = 0;
  int                 stim_count = 0;
  int                 in_accepted = 0;
  int                 out_accepted = 0;
  int                 fail_count = 0;
  int                 idle_cycles = 0;
  int                 in_gap = 0;
  int                 out_stall = 0;
  logic               in_xfer_q = 1'b0;
  logic               out_xfer_q = 1'b0;
  request_t           next_req;
  search_result_t     got_result;
  search_result_t     want_result;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Same probe order as the hardware: half-open window, midpoint rounded down.
  function automatic search_result_t apply_request(logic [1:0] req, logic [31:0] operand);
    search_result_t     res;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        mid;
    logic signed [31:0] key;
    res = '0;
    key = operand;
    case (req)
      REQ_CLEAR: begin
        shadow_count = 0;
      end
      REQ_APPEND: begin
        if (shadow_count >= DEPTH) begin
          res.full_err = 1'b1;
        end else begin
          shadow_values[shadow_count] = key;
          shadow_count++;
        end
      end
      REQ_SEARCH: begin
        lo = 0;
        hi = shadow_count;
        while (hi > lo && !res.found) begin
          mid = lo + (hi - lo) / 2;
          if (shadow_values[mid] == key) begin
            res.found = 1'b1;
            res.match_index = mid[OUT_IDX_W-1:0];
          end else if (key < shadow_values[mid]) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = shadow_count[OUT_CNT_W-1:0];
    return res;
  endfunction

  task automatic queue_request(logic [1:0] req, logic [31:0] operand);
    request_t item;
    item.req = req;
    item.operand = operand;
    pending_requests = {pending_requests, item};
    if (req == REQ_CLEAR) begin
      loaded_keys.delete();
    end else if (req == REQ_APPEND && loaded_keys.size() < DEPTH) begin
      loaded_keys = {loaded_keys, int'(operand)};
    end
    if (req != REQ_UNUSED) stim_count++;
    stim_total++;
  endtask

  // Ascending values with occasional duplicates; about noise_pct percent of the appends take a random value.
  task automatic queue_sorted_load(int n, int unsigned max_step, longint first, int noise_pct);
    longint v;
    v = first;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        queue_request(REQ_APPEND, $urandom());
      end else begin
        queue_request(REQ_APPEND, v[31:0]);
        if ($urandom_range(0, 9) != 0) v = v + $urandom_range(1, max_step);
        if (v > VAL_MAX) v = VAL_MAX;
      end
    end
  endtask

  function automatic int pick_key();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (loaded_keys.size() > 0 && r < 55) begin
      return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
    end
    if (loaded_keys.size() > 0 && r < 75) begin
      k = loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
      return $urandom_range(0, 1) ? k + 1 : k - 1;
    end
    if (r < 85) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    return $urandom();
  endfunction

  initial begin
    int          r;
    int          n;
    int          m;
    int unsigned max_step;
    longint      first;

    // Directed: empty table, extremes, duplicates, misses, unused code, clear, unsorted.
    queue_request(REQ_SEARCH, 32'h0000_0000);
    queue_request(REQ_UNUSED, 32'hFFFF_FFFF);
    queue_request(REQ_APPEND, VAL_MIN);
    queue_request(REQ_APPEND, 32'hFFFF_FFFF);
    queue_request(REQ_APPEND, 32'h0000_0000);
    queue_request(REQ_APPEND, 32'h0000_0000);
    queue_request(REQ_APPEND, 32'h0000_0001);
    queue_request(REQ_APPEND, VAL_MAX);
    queue_request(REQ_SEARCH, VAL_MIN);
    queue_request(REQ_SEARCH, 32'hFFFF_FFFF);
    queue_request(REQ_SEARCH, 32'h0000_0000);
    queue_request(REQ_SEARCH, 32'h0000_0001);
    queue_request(REQ_SEARCH, VAL_MAX);
    queue_request(REQ_SEARCH, 32'h0000_0002);
    queue_request(REQ_SEARCH, 32'hFFFF_FFFE);
    queue_request(REQ_UNUSED, 32'h1234_5678);
    queue_request(REQ_CLEAR, 32'hA5A5_A5A5);
    queue_request(REQ_SEARCH, 32'h0000_0000);
    queue_request(REQ_APPEND, 32'd5);
    queue_request(REQ_APPEND, 32'd3);
    queue_request(REQ_APPEND, 32'd1);
    queue_request(REQ_SEARCH, 32'd3);
    queue_request(REQ_SEARCH, 32'd1);
    queue_request(REQ_SEARCH, 32'd5);
    queue_request(REQ_CLEAR, 32'h5A5A_5A5A);

    // Fill the table completely, overflow it, then search across the full range.
    queue_sorted_load(DEPTH, 1 << 23, VAL_MIN, 0);
    repeat (4) queue_request(REQ_APPEND, $urandom());
    repeat (150) queue_request(REQ_SEARCH, pick_key());
    queue_request(REQ_UNUSED, $urandom());

    while (stim_count < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 85) queue_request(REQ_CLEAR, $urandom());
      r = $urandom_range(0, 99);
      if (r < 75) n = $urandom_range(0, 12);
      else if (r < 95) n = $urandom_range(13, 64);
      else n = $urandom_range(65, 300);
      case ($urandom_range(0, 3))
        0: max_step = 3;
        1: max_step = 255;
        2: max_step = 1 << 16;
        default: max_step = 1 << 26;
      endcase
      first = longint'($signed($urandom()));
      queue_sorted_load(n, max_step, first, 8);
      m = $urandom_range(1, 12);
      repeat (m) begin
        if ($urandom_range(0, 99) < 4) queue_request(REQ_UNUSED, $urandom());
        queue_request(REQ_SEARCH, pick_key());
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (in_accepted < stim_total || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sorted_table_binary_search_unit: PASSED **");
    end else begin
      $display("** sorted_table_binary_search_unit: FAILED **");
    end
    $finish;
  end

  // Request driver: a new item only once the previous one has been transferred.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer_q) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_requests.size() > 0) begin
        next_req = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_req.req;
        in_tdata <= next_req.operand;
        in_gap <= pick_gap((in_accepted / 32) % 4 == 3);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: a random stall follows each transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_xfer_q) begin
      out_stall <= pick_gap((out_accepted / 32) % 4 == 1);
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_xfer_q <= rst_n && in_tvalid && in_tready;
    out_xfer_q <= rst_n && out_tvalid && out_tready;

    if (rst_n && in_tvalid && in_tready) begin
      expected_results = {expected_results, apply_request(in_tuser, in_tdata)};
      in_accepted++;
    end

    if (rst_n && out_tvalid && out_tready) begin
      got_result.found = out_tdata[0];
      got_result.match_index = out_tdata[10:1];
      got_result.full_err = out_tdata[11];
      got_result.entry_count = out_tdata[22:12];
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result transfer with nothing outstanding: found=%0d index=%0d err=%0d count=%0d",
                   got_result.found, got_result.match_index, got_result.full_err,
                   got_result.entry_count);
        end
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.found != want_result.found ||
            got_result.match_index != want_result.match_index ||
            got_result.full_err != want_result.full_err ||
            got_result.entry_count != want_result.entry_count) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d mismatch: expected found=%0d index=%0d err=%0d count=%0d,",
                     out_accepted, want_result.found, want_result.match_index,
                     want_result.full_err, want_result.entry_count);
            $display("  got found=%0d index=%0d err=%0d count=%0d",
                     got_result.found, got_result.match_index, got_result.full_err,
                     got_result.entry_count);
          end
        end
      end
      out_accepted++;
    end

    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("** sorted_table_binary_search_unit: FAILED **");
      $finish;
    end
  end

endmodule

// File: sorted_table_binary_search_unit.f
design/stbs_pkg.sv
design/stbs_ctrl.sv
design/stbs_dp.sv
design/sorted_table_binary_search_unit.sv
verif/testbench.sv
